FILE: hw/rtl/hmbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmbd_pkg
// Shared types, address map and helpers for the handheld bus decoder.
// ----------------------------------------------------------------------------
package hmbd_pkg;

  localparam int unsigned MemDepthDef  = 65536;
  localparam int unsigned DmaLengthDef = 160;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_PRESS   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DMA
  } state_e;

  // address map
  localparam logic [15:0] ADDR_JOYP   = 16'hFF00;
  localparam logic [15:0] ADDR_DIV    = 16'hFF04;
  localparam logic [15:0] ADDR_TAC    = 16'hFF07;
  localparam logic [15:0] ADDR_IF     = 16'hFF0F;
  localparam logic [15:0] ADDR_IE     = 16'hFFFF;
  localparam logic [15:0] ADDR_LCD_LO = 16'hFF40;
  localparam logic [15:0] ADDR_LCD_HI = 16'hFF4B;
  localparam logic [15:0] ADDR_LY     = 16'hFF44;
  localparam logic [15:0] ADDR_DMA    = 16'hFF46;
  localparam logic [15:0] ADDR_VRAM   = 16'h8000;
  localparam logic [7:0]  PAGE_OAM    = 8'hFE;

  // joypad select codes
  localparam logic [7:0] JOY_SEL_HI   = 8'h10;
  localparam logic [7:0] JOY_SEL_LO   = 8'h20;
  localparam logic [7:0] JOY_SEL_NONE = 8'h30;
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;

  // io register file layout
  localparam int unsigned IoCount = 18;
  localparam int unsigned IoIdxW  = $clog2(IoCount);
  localparam int unsigned IDX_DIV = 0;
  localparam int unsigned IDX_IF  = 4;
  localparam int unsigned IDX_IE  = 5;
  localparam int unsigned IDX_LCD = 6;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        press;
    logic        rel;
    logic        tick;
    logic [2:0]  button;
  } reg_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } reg_rd_t;

  function automatic logic is_io(logic [15:0] a);
    logic r;
    r = (a == ADDR_JOYP) || ((a >= ADDR_DIV) && (a <= ADDR_TAC)) || (a == ADDR_IF) ||
        (a == ADDR_IE) || ((a >= ADDR_LCD_LO) && (a <= ADDR_LCD_HI));
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hmbd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmbd_in_if / hmbd_out_if
// Valid/ready channels for bus items and their results.
// ----------------------------------------------------------------------------
interface hmbd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [2:0]  button;

  modport source (output valid, op, address, write_data, button, input ready);
  modport sink   (input valid, op, address, write_data, button, output ready);
endinterface

interface hmbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       divider_reset;

  modport source (output valid, read_data, divider_reset, input ready);
  modport sink   (input valid, read_data, divider_reset, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hmbd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmbd_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hmbd_ram #(
  parameter int unsigned Depth = hmbd_pkg::MemDepthDef,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/hmbd_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmbd_regs
// Timer, interrupt, LCD and joypad registers with their address decode.
// ----------------------------------------------------------------------------
module hmbd_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hmbd_pkg::reg_cmd_t cmd_i,
  input  logic [15:0]        rd_addr_i,
  output hmbd_pkg::reg_rd_t  rd_o
);
  import hmbd_pkg::*;

  logic [7:0] io_q [IoCount];
  logic [7:0] io_d [IoCount];
  logic [7:0] sel_q, sel_d;
  logic [7:0] held_q, held_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] btn_mask;
  logic [7:0] held_n;

  assign btn_mask = 8'b1 << cmd_i.button;
  assign held_n   = ~held_q;

  always_comb begin
    io_d   = io_q;
    sel_d  = sel_q;
    held_d = held_q;
    wait_d = wait_q;
    if (cmd_i.wr) begin
      if (cmd_i.addr == ADDR_JOYP) begin
        if ((cmd_i.data == JOY_SEL_HI) || (cmd_i.data == JOY_SEL_LO)) begin
          sel_d = cmd_i.data;
        end else if (cmd_i.data == JOY_SEL_NONE) begin
          sel_d  = cmd_i.data;
          wait_d = '0;
        end
      end else if (cmd_i.addr == ADDR_DIV) begin
        io_d[IoIdxW'(IDX_DIV)] = '0;
      end else if ((cmd_i.addr > ADDR_DIV) && (cmd_i.addr <= ADDR_TAC)) begin
        io_d[IoIdxW'(IDX_DIV) + IoIdxW'(cmd_i.addr[1:0])] = cmd_i.data;
      end else if (cmd_i.addr == ADDR_IF) begin
        io_d[IoIdxW'(IDX_IF)] = cmd_i.data;
      end else if (cmd_i.addr == ADDR_IE) begin
        io_d[IoIdxW'(IDX_IE)] = cmd_i.data;
      end else if ((cmd_i.addr >= ADDR_LCD_LO) && (cmd_i.addr <= ADDR_LCD_HI) &&
                   (cmd_i.addr != ADDR_LY)) begin
        io_d[IoIdxW'(IDX_LCD) + IoIdxW'(cmd_i.addr[3:0])] = cmd_i.data;
      end
    end
    if (cmd_i.press) begin
      held_d = held_q | btn_mask;
    end
    if (cmd_i.rel) begin
      held_d = held_q & ~btn_mask;
    end
    if (cmd_i.tick && (wait_q != '0)) begin
      wait_d = wait_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_q   <= '{default: '0};
      sel_q  <= '0;
      held_q <= '0;
      wait_q <= '0;
    end else begin
      io_q   <= io_d;
      sel_q  <= sel_d;
      held_q <= held_d;
      wait_q <= wait_d;
    end
  end

  // read decode; anything not claimed here falls through to the byte store
  always_comb begin
    rd_o.hit  = is_io(rd_addr_i);
    rd_o.data = '0;
    if (rd_addr_i == ADDR_JOYP) begin
      if ((sel_q == JOY_SEL_NONE) || (wait_q != '0)) begin
        rd_o.data = '0;
      end else if (sel_q == JOY_SEL_HI) begin
        rd_o.data = {4'h0, held_n[7:4] & NIBBLE_MASK};
      end else if (sel_q == JOY_SEL_LO) begin
        rd_o.data = {4'h0, held_n[3:0] & NIBBLE_MASK};
      end
    end else if ((rd_addr_i >= ADDR_DIV) && (rd_addr_i <= ADDR_TAC)) begin
      rd_o.data = io_q[IoIdxW'(IDX_DIV) + IoIdxW'(rd_addr_i[1:0])];
    end else if (rd_addr_i == ADDR_IF) begin
      rd_o.data = io_q[IoIdxW'(IDX_IF)];
    end else if (rd_addr_i == ADDR_IE) begin
      rd_o.data = io_q[IoIdxW'(IDX_IE)];
    end else if ((rd_addr_i >= ADDR_LCD_LO) && (rd_addr_i <= ADDR_LCD_HI)) begin
      rd_o.data = io_q[IoIdxW'(IDX_LCD) + IoIdxW'(rd_addr_i[3:0])];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/handheld_memory_bus_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_memory_bus_decoder_core
// 16-bit bus decoder: io registers, joypad and a 64K byte store, with an
// OAM copy engine started by a write to the DMA register.
// ----------------------------------------------------------------------------
//   channel  dir  payload                            handshake
//   in_i     in   op, address, write_data, button    valid/ready
//   out_o    out  read_data, divider_reset           valid/ready
//
// One item at a time. Write and button/tick items set the result register
// when taken; reads wait in ST_READ for the registered byte store data. A
// write to FF46 runs the OAM copy, one byte read and one written per cycle.
// The result register holds a stalled result; the next item is taken once it
// is free or leaving. No clearing pass after reset: the store is undefined.
// ----------------------------------------------------------------------------
module handheld_memory_bus_decoder_core #(
  parameter int unsigned MEM_DEPTH  = hmbd_pkg::MemDepthDef,
  parameter int unsigned DMA_LENGTH = hmbd_pkg::DmaLengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hmbd_in_if.sink    in_i,
  hmbd_out_if.source out_o
);
  import hmbd_pkg::*;

  localparam int unsigned AW   = $clog2(MEM_DEPTH);
  localparam int unsigned CntW = $clog2(DMA_LENGTH + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      page_q, page_d;
  logic [7:0]      dma_off_q, dma_off_d;
  logic [15:0]     rd_addr_q, rd_addr_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_rd_q, out_rd_d;
  logic            out_dr_q, out_dr_d;

  logic            in_acc;
  logic            mem_we, mem_re;
  logic [15:0]     mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;
  logic [7:0]      fetched;
  reg_cmd_t        reg_cmd;
  reg_rd_t         reg_rd;

  hmbd_ram #(.Depth(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(mem_waddr)),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(mem_raddr)),
    .rdata_o (mem_rdata)
  );

  hmbd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (reg_cmd),
    .rd_addr_i (rd_addr_q),
    .rd_o      (reg_rd)
  );

  // byte at the address issued last cycle, through the full decode
  assign fetched = reg_rd.hit ? reg_rd.data : mem_rdata;

  assign in_i.ready          = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc              = in_i.valid && in_i.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_rd_q;
  assign out_o.divider_reset = out_dr_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    page_d         = page_q;
    dma_off_d      = dma_off_q;
    rd_addr_d      = rd_addr_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_rd_d       = out_rd_q;
    out_dr_d       = out_dr_q;
    mem_we         = 1'b0;
    mem_waddr      = in_i.address;
    mem_wdata      = in_i.write_data;
    mem_re         = 1'b0;
    mem_raddr      = in_i.address;
    reg_cmd        = '0;
    reg_cmd.addr   = in_i.address;
    reg_cmd.data   = in_i.write_data;
    reg_cmd.button = in_i.button;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_rd_d = '0;
          out_dr_d = 1'b0;
          unique case (op_e'(in_i.op))
            OP_READ: begin
              mem_re    = 1'b1;
              rd_addr_d = in_i.address;
              state_d   = ST_READ;
            end
            OP_WRITE: begin
              if (in_i.address == ADDR_DMA) begin
                page_d  = in_i.write_data;
                cnt_d   = '0;
                state_d = ST_DMA;
              end else begin
                reg_cmd.wr  = 1'b1;
                mem_we      = (in_i.address >= ADDR_VRAM) && !is_io(in_i.address);
                out_dr_d    = (in_i.address == ADDR_DIV);
                out_valid_d = 1'b1;
              end
            end
            OP_PRESS: begin
              reg_cmd.press = 1'b1;
              out_valid_d   = 1'b1;
            end
            OP_RELEASE: begin
              reg_cmd.rel = 1'b1;
              out_valid_d = 1'b1;
            end
            OP_TICK: begin
              reg_cmd.tick = 1'b1;
              out_valid_d  = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_rd_d    = fetched;
        out_dr_d    = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_DMA: begin
        // write back the byte fetched last cycle while the next one is read
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = {PAGE_OAM, dma_off_q};
          mem_wdata = fetched;
        end
        if (cnt_q == CntW'(DMA_LENGTH)) begin
          reg_cmd.wr   = 1'b1;
          reg_cmd.addr = ADDR_DMA;
          reg_cmd.data = page_q;
          out_valid_d  = 1'b1;
          out_rd_d     = '0;
          out_dr_d     = 1'b0;
          state_d      = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {page_q, 8'(cnt_q)};
          rd_addr_d = {page_q, 8'(cnt_q)};
          dma_off_d = 8'(cnt_q);
          cnt_d     = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    dma_off_q <= dma_off_d;
    rd_addr_q <= rd_addr_d;
    out_rd_q  <= out_rd_d;
    out_dr_q  <= out_dr_d;
  end

  a_no_low_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> mem_waddr >= ADDR_VRAM)
    else $error("byte store written below 8000");

  a_dma_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DMA) |-> (cnt_q <= CntW'(DMA_LENGTH)))
    else $error("copy counter past length");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (out_valid_q && !out_dr_q))
    else $error("read did not yield a result");

  a_div_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dr_q) |-> (out_rd_q == '0))
    else $error("divider reset with read data");

endmodule
`default_nettype wire
